/* hw/rtl/servo_pulse_command_failsafe_top_assert.svh */
// assertion macros shared by the servo command unit rtl
`ifndef SERVO_PULSE_COMMAND_FAILSAFE_TOP_ASSERT_SVH
`define SERVO_PULSE_COMMAND_FAILSAFE_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SPCF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spcf assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define SPCF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spcf assertion failed");

`endif

/* hw/rtl/spcf_pkg.sv */
// types, codes and constants of the servo command unit
package spcf_pkg;

    // request type codes
    localparam logic [2:0] REQ_START    = 3'd0;
    localparam logic [2:0] REQ_UNITLESS = 3'd1;
    localparam logic [2:0] REQ_RAW      = 3'd2;
    localparam logic [2:0] REQ_TICK     = 3'd3;
    localparam logic [2:0] REQ_STATUS   = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_MIN_PULSE = 3'd0;
    localparam logic [2:0] CFG_MAX_PULSE = 3'd1;
    localparam logic [2:0] CFG_NEUTRAL   = 3'd2;
    localparam logic [2:0] CFG_PERIOD    = 3'd3;
    localparam logic [2:0] CFG_RELOAD    = 3'd4;
    localparam logic [2:0] CFG_CHAN_ID   = 3'd5;
    localparam logic [2:0] CFG_TIMEOUT   = 3'd6;

    // configuration reset values
    localparam logic [15:0] RST_MIN_PULSE = 16'd1000;
    localparam logic [15:0] RST_MAX_PULSE = 16'd2000;
    localparam logic [15:0] RST_NEUTRAL   = 16'd1500;
    localparam logic [19:0] RST_PERIOD    = 20'd20000;
    localparam logic [15:0] RST_RELOAD    = 16'd65535;
    localparam logic [7:0]  RST_CHAN_ID   = 8'd5;
    localparam logic [15:0] RST_TIMEOUT   = 16'd500;

    // one servo channel exists
    localparam logic [7:0] SERVO_COUNT = 8'd1;

    // shared divider geometry
    localparam int DIV_N_W   = 32;
    localparam int DIV_D_W   = 20;
    localparam int DIV_CNT_W = $clog2(DIV_N_W);

    // how an accepted word is processed
    typedef enum logic [1:0] {
        KIND_DIRECT,
        KIND_NEUTRAL,
        KIND_SCALE,
        KIND_RAW
    } kind_t;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCALE_MUL,
        S_SCALE_CLAMP,
        S_TICK_MUL,
        S_TICK_START,
        S_TICK_DIV,
        S_TICK_FIN,
        S_POS_START,
        S_POS_DIV,
        S_POS_FIN,
        S_DONE
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load_item;
        logic scale_mul;
        logic scale_clamp;
        logic tick_mul;
        logic tick_div_start;
        logic tick_fin;
        logic pos_div_start;
        logic pos_fin;
        logic out_load;
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        kind_t kind;
        logic  div_busy;
        logic  out_free;
    } dp_sts_t;

endpackage

/* hw/rtl/spcf_div.sv */
// iterative restoring divider, one quotient bit per cycle
module spcf_div
    import spcf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_N_W-1:0] dividend,
    input  logic [DIV_D_W-1:0] divisor,
    output logic               busy,
    output logic [DIV_N_W-1:0] quotient,
    output logic [DIV_D_W-1:0] remainder
);

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_N_W-1:0]   quo_reg;
    logic [DIV_D_W-1:0]   rem_reg;
    logic [DIV_D_W-1:0]   dsr_reg;
    logic [DIV_D_W:0]     rem_sh;
    logic [DIV_D_W+1:0]   diff;

    // shift in the next dividend bit and trial subtract
    assign rem_sh = {rem_reg, quo_reg[DIV_N_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, dsr_reg};

    // control: busy flag and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_W'(DIV_N_W - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // datapath: quotient shifts in as the dividend shifts out
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[DIV_D_W+1])
            begin
                rem_reg <= diff[DIV_D_W-1:0];
                quo_reg <= {quo_reg[DIV_N_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[DIV_D_W-1:0];
                quo_reg <= {quo_reg[DIV_N_W-2:0], 1'b0};
            end
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

/* hw/rtl/spcf_dp.sv */
// datapath: config registers, channel state, multiplier, divider, result register
`include "servo_pulse_command_failsafe_top_assert.svh"

module spcf_dp
    import spcf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic [2:0]         cfg_index,
    input  logic [19:0]        cfg_data,
    input  logic [2:0]         req_type,
    input  logic [7:0]         servo_index,
    input  logic signed [15:0] position_cmd,
    input  logic [15:0]        pulse_cmd_us,
    input  logic [31:0]        now_ms,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        compare_ticks,
    output logic               compare_write,
    output logic               failsafe_fired,
    output logic               status_ok,
    output logic [7:0]         status_id,
    output logic signed [15:0] status_position,
    input  ctrl_cmd_t          cmd,
    output dp_sts_t            sts
);

    // configuration
    logic [15:0] min_pulse_reg;
    logic [15:0] max_pulse_reg;
    logic [15:0] neutral_reg;
    logic [19:0] period_reg;
    logic [15:0] reload_reg;
    logic [7:0]  chan_id_reg;
    logic [15:0] timeout_reg;

    // channel state
    logic [15:0] last_pos_reg;
    logic [31:0] last_time_reg;

    // item registers
    kind_t       kind_reg;
    kind_t       kind_next;
    logic [2:0]  req_reg;
    logic        idx_ok_reg;
    logic [15:0] pos_reg;
    logic [31:0] now_reg;
    logic [15:0] us_reg;
    logic [15:0] us_load;
    logic [15:0] cmp_val_reg;
    logic [15:0] pos_res_reg;
    logic signed [34:0] prod_reg;

    // result register
    logic        out_valid_reg;
    logic [15:0] compare_ticks_reg;
    logic        compare_write_reg;
    logic        failsafe_reg;
    logic        status_ok_reg;
    logic [7:0]  status_id_reg;
    logic [15:0] status_pos_reg;

    // combinational helpers
    logic               idx_ok;
    logic               fire;
    logic [16:0]        range_w;
    logic [16:0]        top_w;
    logic signed [16:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [34:0] prod;
    logic [35:0]        num;
    logic [35:0]        mag;
    logic [35:0]        qsum;
    logic [20:0]        vs;
    logic [15:0]        us_scaled;
    logic [16:0]        d_w;
    logic [16:0]        dmag;
    logic [16:0]        rmag;
    logic               div_start;
    logic [DIV_N_W-1:0] div_dividend;
    logic [DIV_D_W-1:0] div_divisor;
    logic               div_busy;
    logic [DIV_N_W-1:0] div_quo;
    logic [DIV_D_W-1:0] div_rem;
    logic               tick_rnd;
    logic [32:0]        tick_q;
    logic [15:0]        tick_val;
    logic               pos_rnd;
    logic [32:0]        pos_q;
    logic [15:0]        pos_val;
    logic               pos_neg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_pulse_reg <= RST_MIN_PULSE;
            max_pulse_reg <= RST_MAX_PULSE;
            neutral_reg   <= RST_NEUTRAL;
            period_reg    <= RST_PERIOD;
            reload_reg    <= RST_RELOAD;
            chan_id_reg   <= RST_CHAN_ID;
            timeout_reg   <= RST_TIMEOUT;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MIN_PULSE: min_pulse_reg <= cfg_data[15:0];
                CFG_MAX_PULSE: max_pulse_reg <= cfg_data[15:0];
                CFG_NEUTRAL:   neutral_reg   <= cfg_data[15:0];
                CFG_PERIOD:    period_reg    <= cfg_data;
                CFG_RELOAD:    reload_reg    <= cfg_data[15:0];
                CFG_CHAN_ID:   chan_id_reg   <= cfg_data[7:0];
                CFG_TIMEOUT:   timeout_reg   <= cfg_data[15:0];
                default:       ;
            endcase
        end
    end

    // decode of the incoming word
    assign idx_ok = (servo_index < SERVO_COUNT);
    assign fire   = ((now_ms - last_time_reg) > {16'd0, timeout_reg});

    always_comb
    begin
        case (req_type)
            REQ_START:    kind_next = KIND_NEUTRAL;
            REQ_UNITLESS: kind_next = idx_ok ? KIND_SCALE : KIND_DIRECT;
            REQ_RAW:      kind_next = idx_ok ? KIND_RAW : KIND_DIRECT;
            REQ_TICK:     kind_next = fire ? KIND_NEUTRAL : KIND_DIRECT;
            default:      kind_next = KIND_DIRECT;
        endcase
    end

    // pulse seeded at load: clamped raw pulse or neutral
    always_comb
    begin
        if (req_type == REQ_RAW)
        begin
            if (pulse_cmd_us < min_pulse_reg)
            begin
                us_load = min_pulse_reg;
            end
            else if (pulse_cmd_us > max_pulse_reg)
            begin
                us_load = max_pulse_reg;
            end
            else
            begin
                us_load = pulse_cmd_us;
            end
        end
        else
        begin
            us_load = neutral_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= KIND_DIRECT;
        end
        else if (cmd.load_item)
        begin
            kind_reg <= kind_next;
        end
    end

    // shared multiplier: position times range, or pulse times timer top
    assign range_w = {1'b0, max_pulse_reg} - {1'b0, min_pulse_reg};
    assign top_w   = {1'b0, reload_reg} + 17'd1;
    assign mul_a   = cmd.scale_mul ? {pos_reg[15], pos_reg} : {1'b0, us_reg};
    assign mul_b   = cmd.scale_mul ? {range_w[16], range_w} : {1'b0, top_w};
    assign prod    = mul_a * mul_b;

    // unitless position to microseconds, rounded half away from zero, clamped to the pulse window
    assign num  = {4'd0, neutral_reg, 16'd0} + {prod_reg[34], prod_reg};
    assign mag  = num[35] ? (36'd0 - num) : num;
    assign qsum = mag + 36'd32768;
    assign vs   = num[35] ? (21'd0 - {1'b0, qsum[35:16]}) : {1'b0, qsum[35:16]};

    always_comb
    begin
        if ($signed(vs) < $signed({5'd0, min_pulse_reg}))
        begin
            us_scaled = min_pulse_reg;
        end
        else if ($signed(vs) > $signed({5'd0, max_pulse_reg}))
        begin
            us_scaled = max_pulse_reg;
        end
        else
        begin
            us_scaled = vs[15:0];
        end
    end

    // divider operands: ticks division or position back-conversion
    assign d_w   = {1'b0, us_reg} - {1'b0, neutral_reg};
    assign dmag  = d_w[16] ? (17'd0 - d_w) : d_w;
    assign rmag  = range_w[16] ? (17'd0 - range_w) : range_w;
    assign div_start    = cmd.tick_div_start | cmd.pos_div_start;
    assign div_dividend = cmd.pos_div_start ? {dmag[15:0], 16'd0} : prod_reg[31:0];
    assign div_divisor  = cmd.pos_div_start ? {4'd0, rmag[15:0]} : period_reg;

    spcf_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // ticks: round quotient, saturate at reload
    assign tick_rnd = ({div_rem, 1'b0} >= {1'b0, period_reg});
    assign tick_q   = {1'b0, div_quo} + {32'd0, tick_rnd};
    assign tick_val = (tick_q > {17'd0, reload_reg}) ? reload_reg : tick_q[15:0];

    // position: round quotient, apply sign, saturate to q1.15
    assign pos_rnd = ({div_rem, 1'b0} >= {5'd0, rmag[15:0]});
    assign pos_q   = {1'b0, div_quo} + {32'd0, pos_rnd};
    assign pos_neg = d_w[16] ^ range_w[16];

    always_comb
    begin
        if (d_w == 17'd0)
        begin
            pos_val = 16'd0;
        end
        else if (pos_neg)
        begin
            pos_val = (pos_q > 33'd32768) ? 16'h8000 : 16'(17'd0 - pos_q[16:0]);
        end
        else
        begin
            pos_val = (pos_q > 33'd32767) ? 16'h7fff : pos_q[15:0];
        end
    end

    // item payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            req_reg    <= req_type;
            idx_ok_reg <= idx_ok;
            pos_reg    <= position_cmd;
            now_reg    <= now_ms;
            us_reg     <= us_load;
        end
        else if (cmd.scale_clamp)
        begin
            us_reg <= us_scaled;
        end
        if (cmd.scale_mul || cmd.tick_mul)
        begin
            prod_reg <= prod;
        end
        if (cmd.tick_fin)
        begin
            cmp_val_reg <= tick_val;
        end
        if (cmd.pos_fin)
        begin
            pos_res_reg <= pos_val;
        end
    end

    // channel state update when the result is issued
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_pos_reg  <= '0;
            last_time_reg <= '0;
        end
        else if (cmd.out_load)
        begin
            case (kind_reg)
                KIND_NEUTRAL:
                begin
                    last_pos_reg  <= '0;
                    last_time_reg <= (req_reg == REQ_TICK) ? 32'd0 : now_reg;
                end
                KIND_SCALE:
                begin
                    last_pos_reg  <= pos_reg;
                    last_time_reg <= now_reg;
                end
                KIND_RAW:
                begin
                    last_pos_reg  <= pos_res_reg;
                    last_time_reg <= now_reg;
                end
                default: ;
            endcase
        end
    end

    // result word valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result word fields
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            compare_write_reg <= (kind_reg != KIND_DIRECT);
            compare_ticks_reg <= (kind_reg != KIND_DIRECT) ? cmp_val_reg : 16'd0;
            failsafe_reg      <= (kind_reg == KIND_NEUTRAL) && (req_reg == REQ_TICK);
            if ((kind_reg == KIND_DIRECT) && (req_reg == REQ_STATUS) && idx_ok_reg)
            begin
                status_ok_reg  <= 1'b1;
                status_id_reg  <= chan_id_reg;
                status_pos_reg <= last_pos_reg;
            end
            else
            begin
                status_ok_reg  <= 1'b0;
                status_id_reg  <= 8'd0;
                status_pos_reg <= 16'd0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign compare_ticks   = compare_ticks_reg;
    assign compare_write   = compare_write_reg;
    assign failsafe_fired  = failsafe_reg;
    assign status_ok       = status_ok_reg;
    assign status_id       = status_id_reg;
    assign status_position = status_pos_reg;

    // status to the controller
    assign sts.kind     = kind_reg;
    assign sts.div_busy = div_busy;
    assign sts.out_free = !out_valid_reg || out_ready;

    // a failsafe always rewrites the compare register
    `SPCF_ASSERT_NOW(a_fire_writes, out_valid && failsafe_fired, compare_write)
    // status replies never carry a compare update
    `SPCF_ASSERT_NOW(a_status_excl, out_valid && status_ok, !compare_write)
    // a stalled result word stays offered
    `SPCF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

endmodule

/* hw/rtl/spcf_ctrl.sv */
// controller state machine sequencing the datapath
`include "servo_pulse_command_failsafe_top_assert.svh"

module spcf_ctrl
    import spcf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output ctrl_cmd_t cmd,
    input  dp_sts_t   sts
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (sts.kind)
                    KIND_SCALE:   state_next = S_SCALE_MUL;
                    KIND_NEUTRAL: state_next = S_TICK_MUL;
                    KIND_RAW:     state_next = S_TICK_MUL;
                    default:      state_next = S_DONE;
                endcase
            end
            S_SCALE_MUL:   state_next = S_SCALE_CLAMP;
            S_SCALE_CLAMP: state_next = S_TICK_MUL;
            S_TICK_MUL:    state_next = S_TICK_START;
            S_TICK_START:  state_next = S_TICK_DIV;
            S_TICK_DIV:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_TICK_FIN;
                end
            end
            S_TICK_FIN:
            begin
                state_next = (sts.kind == KIND_RAW) ? S_POS_START : S_DONE;
            end
            S_POS_START:   state_next = S_POS_DIV;
            S_POS_DIV:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_POS_FIN;
                end
            end
            S_POS_FIN:     state_next = S_DONE;
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:       state_next = S_IDLE;
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
            end
            S_SCALE_MUL:   cmd.scale_mul      = 1'b1;
            S_SCALE_CLAMP: cmd.scale_clamp    = 1'b1;
            S_TICK_MUL:    cmd.tick_mul       = 1'b1;
            S_TICK_START:  cmd.tick_div_start = 1'b1;
            S_TICK_FIN:    cmd.tick_fin       = 1'b1;
            S_POS_START:   cmd.pos_div_start  = 1'b1;
            S_POS_FIN:     cmd.pos_fin        = 1'b1;
            S_DONE:        cmd.out_load       = sts.out_free;
            default:       ;
        endcase
    end

    // result only written into a free output register
    `SPCF_ASSERT_NOW(a_load_free, cmd.out_load, sts.out_free)
    // divider never restarted mid-run
    `SPCF_ASSERT_NOW(a_start_idle, cmd.tick_div_start || cmd.pos_div_start, !sts.div_busy)
    // a started division is running on the next cycle
    `SPCF_ASSERT_NEXT(a_div_runs, cmd.tick_div_start || cmd.pos_div_start, sts.div_busy)

endmodule

/* hw/rtl/servo_pulse_command_failsafe_top.sv */
// servo command unit with failsafe: top level
// Usage:
//   in channel (in_valid/in_ready) takes one request word: req_type,
//   servo_index, position_cmd, pulse_cmd_us, now_ms.
//   out channel (out_valid/out_ready) returns exactly one result word per
//   request: compare_ticks/compare_write, failsafe_fired, status fields.
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes one
//   register per accepted word; cfg_ready is always high; write only while
//   no request is in flight.
// Timing: one request at a time; the next one is accepted the cycle after
//   a result is loaded. Status, non-firing ticks and rejected commands
//   go straight to the result; start and failsafe ticks run one division;
//   unitless commands scale and clamp first; raw pulse commands add a
//   second division. The iterative divider is shared: one division for
//   compare ticks, a second for the raw pulse position back-conversion.
// Reset: registers return to their default values, channel position and
//   update time clear, no result pending.
// Stall: a finished result waits in the output register; a new request
//   is accepted meanwhile and runs until its own result is ready to load.
module servo_pulse_command_failsafe_top
    import spcf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [19:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         req_type,
    input  logic [7:0]         servo_index,
    input  logic signed [15:0] position_cmd,
    input  logic [15:0]        pulse_cmd_us,
    input  logic [31:0]        now_ms,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        compare_ticks,
    output logic               compare_write,
    output logic               failsafe_fired,
    output logic               status_ok,
    output logic [7:0]         status_id,
    output logic signed [15:0] status_position
);

    ctrl_cmd_t cmd;
    dp_sts_t   sts;

    // register writes always accepted
    assign cfg_ready = 1'b1;

    // sequencer
    spcf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // arithmetic and storage
    spcf_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .req_type        (req_type),
        .servo_index     (servo_index),
        .position_cmd    (position_cmd),
        .pulse_cmd_us    (pulse_cmd_us),
        .now_ms          (now_ms),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .compare_ticks   (compare_ticks),
        .compare_write   (compare_write),
        .failsafe_fired  (failsafe_fired),
        .status_ok       (status_ok),
        .status_id       (status_id),
        .status_position (status_position),
        .cmd             (cmd),
        .sts             (sts)
    );

endmodule

/* bench/tb.sv */
// self-checking testbench for the servo command unit with failsafe
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import spcf_pkg::*;

    // request codes the block must ignore, and the unused register index
    localparam logic [2:0] REQ_RSVD5  = 3'd5;
    localparam logic [2:0] REQ_RSVD6  = 3'd6;
    localparam logic [2:0] REQ_RSVD7  = 3'd7;
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    localparam int N_DIRECTED      = 25;
    localparam int N_PHASES        = 12;
    localparam int ITEMS_PER_PHASE = 78;
    localparam int HOLD_PHASE      = 2;
    localparam int PAUSE_PHASE     = 3;
    localparam int STEADY_PHASE    = 6;
    localparam int RX_HOLD_CYCLES  = 300;
    localparam int FLUSH_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT  = 3000;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  servo_idx;
        logic [15:0] position;
        logic [15:0] pulse_us;
        logic [31:0] now;
    } servo_item_t;

    typedef struct packed {
        logic [15:0] ticks;
        logic        cmp_wr;
        logic        fired;
        logic        ok;
        logic [7:0]  id;
        logic [15:0] position;
    } servo_result_t;

    typedef struct packed {
        logic [15:0] min_us;
        logic [15:0] max_us;
        logic [15:0] neutral_us;
        logic [19:0] frame_us;
        logic [15:0] reload;
        logic [7:0]  chan_id;
        logic [15:0] timeout_ms;
    } servo_settings_t;

    typedef struct packed {
        servo_item_t   item;
        logic          typed;
        servo_result_t want;
    } directed_row_t;

    localparam servo_result_t NO_REPLY = '0;
    localparam servo_settings_t RESET_SETTINGS = '{RST_MIN_PULSE, RST_MAX_PULSE,
        RST_NEUTRAL, RST_PERIOD, RST_RELOAD, RST_CHAN_ID, RST_TIMEOUT};

    // directed words at reset settings; typed replies are read straight off the spec
    localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{'{REQ_STATUS,   8'd0,   16'h0000, 16'd0,    32'd0},    1'b1,
          '{16'd0, 1'b0, 1'b0, 1'b1, 8'd5, 16'h0000}},
        '{'{REQ_STATUS,   8'hFF,  16'h0000, 16'd0,    32'd0},    1'b1, NO_REPLY},
        '{'{REQ_START,    8'hA5,  16'h7FFF, 16'd0,    32'd1000}, 1'b1,
          '{16'd4915, 1'b1, 1'b0, 1'b0, 8'd0, 16'h0000}},
        '{'{REQ_UNITLESS, 8'd0,   16'h8000, 16'd0,    32'd1010}, 1'b1,
          '{16'd3277, 1'b1, 1'b0, 1'b0, 8'd0, 16'h0000}},
        '{'{REQ_STATUS,   8'd0,   16'h0000, 16'd0,    32'd1015}, 1'b1,
          '{16'd0, 1'b0, 1'b0, 1'b1, 8'd5, 16'h8000}},
        '{'{REQ_UNITLESS, 8'd0,   16'h7FFF, 16'd0,    32'd1020}, 1'b1,
          '{16'd6554, 1'b1, 1'b0, 1'b0, 8'd0, 16'h0000}},
        '{'{REQ_UNITLESS, 8'd0,   16'h0000, 16'hFFFF, 32'd1025}, 1'b1,
          '{16'd4915, 1'b1, 1'b0, 1'b0, 8'd0, 16'h0000}},
        '{'{REQ_UNITLESS, 8'd1,   16'h4000, 16'd0,    32'd1027}, 1'b1, NO_REPLY},
        '{'{REQ_RAW,      8'd0,   16'h0000, 16'd0,    32'd1030}, 1'b1,
          '{16'd3277, 1'b1, 1'b0, 1'b0, 8'd0, 16'h0000}},
        '{'{REQ_STATUS,   8'd0,   16'h0000, 16'd0,    32'd1035}, 1'b1,
          '{16'd0, 1'b0, 1'b0, 1'b1, 8'd5, 16'h8000}},
        '{'{REQ_RAW,      8'd0,   16'h0000, 16'hFFFF, 32'd1040}, 1'b1,
          '{16'd6554, 1'b1, 1'b0, 1'b0, 8'd0, 16'h0000}},
        '{'{REQ_STATUS,   8'd0,   16'h0000, 16'd0,    32'd1042}, 1'b1,
          '{16'd0, 1'b0, 1'b0, 1'b1, 8'd5, 16'h7FFF}},
        '{'{REQ_RAW,      8'hFF,  16'h0000, 16'd1700, 32'd1045}, 1'b1, NO_REPLY},
        '{'{REQ_RAW,      8'd0,   16'h0000, 16'd1234, 32'd1050}, 1'b0, NO_REPLY},
        '{'{REQ_UNITLESS, 8'd0,   16'h1234, 16'd0,    32'd1060}, 1'b0, NO_REPLY},
        '{'{REQ_TICK,     8'd0,   16'h0000, 16'd0,    32'd1560}, 1'b1, NO_REPLY},
        '{'{REQ_TICK,     8'h80,  16'h0000, 16'd0,    32'd1561}, 1'b1,
          '{16'd4915, 1'b1, 1'b1, 1'b0, 8'd0, 16'h0000}},
        '{'{REQ_STATUS,   8'd0,   16'h0000, 16'd0,    32'd1562}, 1'b1,
          '{16'd0, 1'b0, 1'b0, 1'b1, 8'd5, 16'h0000}},
        '{'{REQ_TICK,     8'd0,   16'h0000, 16'd0,    32'd500},  1'b1, NO_REPLY},
        '{'{REQ_TICK,     8'd0,   16'h0000, 16'd0,    32'd501},  1'b1,
          '{16'd4915, 1'b1, 1'b1, 1'b0, 8'd0, 16'h0000}},
        '{'{REQ_START,    8'd0,   16'h0000, 16'd0,    32'hFFFF_FF00}, 1'b1,
          '{16'd4915, 1'b1, 1'b0, 1'b0, 8'd0, 16'h0000}},
        '{'{REQ_TICK,     8'd0,   16'h0000, 16'd0,    32'h0000_0100}, 1'b1,
          '{16'd4915, 1'b1, 1'b1, 1'b0, 8'd0, 16'h0000}},
        '{'{REQ_RSVD5,    8'd0,   16'h1111, 16'd1500, 32'h0000_1200}, 1'b1, NO_REPLY},
        '{'{REQ_RSVD6,    8'hFF,  16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF}, 1'b1, NO_REPLY},
        '{'{REQ_RSVD7,    8'd0,   16'h0000, 16'd0,    32'd0},    1'b1, NO_REPLY}
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [19:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [2:0]         req_type = '0;
    logic [7:0]         servo_index = '0;
    logic signed [15:0] position_cmd = '0;
    logic [15:0]        pulse_cmd_us = '0;
    logic [31:0]        now_ms = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [15:0]        compare_ticks;
    logic               compare_write;
    logic               failsafe_fired;
    logic               status_ok;
    logic [7:0]         status_id;
    logic signed [15:0] status_position;

    // predictor state and settings
    servo_settings_t servo_cfg = RESET_SETTINGS;
    logic [15:0]     servo_pos = '0;
    logic [31:0]     servo_time = '0;
    logic [31:0]     wall_ms = '0;

    servo_result_t pending_replies [$];
    int            fail_count = 0;
    int            quiet_cycles = 0;
    int            hold_requests = 0;
    logic          idle_on = 1'b1;

    servo_pulse_command_failsafe_top DUT (.*);

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // round to nearest, half away from zero
    function automatic longint round_div(input longint num, input longint den);
        bit              neg;
        longint unsigned an;
        longint unsigned ad;
        longint unsigned q;
        neg = (num < 0) != (den < 0);
        an = (num < 0) ? -num : num;
        ad = (den < 0) ? -den : den;
        q = (2 * an + ad) / (2 * ad);
        return neg ? -longint'(q) : longint'(q);
    endfunction

    // pulse width to timer compare ticks, saturated at the reload value
    function automatic logic [15:0] pulse_to_compare(input logic [15:0] us);
        longint unsigned top;
        longint unsigned per;
        longint unsigned t;
        if (servo_cfg.frame_us == '0)
            return servo_cfg.reload;
        top = 64'(servo_cfg.reload) + 64'd1;
        per = 64'(servo_cfg.frame_us);
        t = (64'd2 * 64'(us) * top + per) / (64'd2 * per);
        if (t > 64'(servo_cfg.reload))
            t = 64'(servo_cfg.reload);
        return t[15:0];
    endfunction

    // lower bound is tested first, so min above max gives max for most values
    function automatic logic [15:0] clamp_pulse(input longint v);
        if (v < longint'(servo_cfg.min_us))
            return servo_cfg.min_us;
        if (v > longint'(servo_cfg.max_us))
            return servo_cfg.max_us;
        return v[15:0];
    endfunction

    // reply to one request word, advancing the channel state
    function automatic servo_result_t servo_reply(input servo_item_t it);
        servo_result_t r;
        longint        range;
        longint        v;
        longint        pos;
        logic [15:0]   us;
        logic [31:0]   since;
        r = '0;
        range = longint'(servo_cfg.max_us) - longint'(servo_cfg.min_us);
        case (it.req_type)
            REQ_START:
            begin
                r.ticks = pulse_to_compare(servo_cfg.neutral_us);
                r.cmp_wr = 1'b1;
                servo_pos = '0;
                servo_time = it.now;
            end
            REQ_UNITLESS:
            begin
                if (it.servo_idx < SERVO_COUNT)
                begin
                    pos = longint'($signed(it.position));
                    v = round_div(longint'(servo_cfg.neutral_us) * 65536 + pos * range,
                                  65536);
                    us = clamp_pulse(v);
                    r.ticks = pulse_to_compare(us);
                    r.cmp_wr = 1'b1;
                    servo_pos = it.position;
                    servo_time = it.now;
                end
            end
            REQ_RAW:
            begin
                if (it.servo_idx < SERVO_COUNT)
                begin
                    us = clamp_pulse(longint'(it.pulse_us));
                    r.ticks = pulse_to_compare(us);
                    r.cmp_wr = 1'b1;
                    v = longint'(us) - longint'(servo_cfg.neutral_us);
                    // zero pulse range: position goes to full scale by sign
                    if (range == 0)
                        v = (v > 0) ? 32767 : ((v < 0) ? -32768 : 0);
                    else
                        v = round_div(v * 65536, range);
                    if (v > 32767)
                        v = 32767;
                    if (v < -32768)
                        v = -32768;
                    servo_pos = v[15:0];
                    servo_time = it.now;
                end
            end
            REQ_TICK:
            begin
                // wrapping silence; the update time is zeroed so it keeps firing
                since = it.now - servo_time;
                if (since > 32'(servo_cfg.timeout_ms))
                begin
                    r.ticks = pulse_to_compare(servo_cfg.neutral_us);
                    r.cmp_wr = 1'b1;
                    r.fired = 1'b1;
                    servo_pos = '0;
                    servo_time = '0;
                end
            end
            REQ_STATUS:
            begin
                if (it.servo_idx < SERVO_COUNT)
                begin
                    r.ok = 1'b1;
                    r.id = servo_cfg.chan_id;
                    r.position = servo_pos;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // mostly well-formed commands, some rejected indexes and undefined codes
    function automatic servo_item_t random_item();
        servo_item_t it;
        int          pick;
        int          lo;
        int          hi;
        int          span;
        pick = $urandom_range(99);
        if (pick < 10)
            it.req_type = REQ_START;
        else if (pick < 40)
            it.req_type = REQ_UNITLESS;
        else if (pick < 65)
            it.req_type = REQ_RAW;
        else if (pick < 85)
            it.req_type = REQ_TICK;
        else if (pick < 97)
            it.req_type = REQ_STATUS;
        else
            it.req_type = 3'($urandom);
        it.servo_idx = ($urandom_range(99) < 85) ? 8'd0 : 8'($urandom);
        pick = $urandom_range(99);
        if (pick < 10)
            it.position = 16'h8000;
        else if (pick < 20)
            it.position = 16'h7FFF;
        else
            it.position = 16'($urandom);
        // pulses around the configured window, or anywhere
        lo = (servo_cfg.min_us < servo_cfg.max_us) ? servo_cfg.min_us : servo_cfg.max_us;
        hi = (servo_cfg.min_us < servo_cfg.max_us) ? servo_cfg.max_us : servo_cfg.min_us;
        lo = (lo > 200) ? lo - 200 : 0;
        hi = (hi + 200 > 65535) ? 65535 : hi + 200;
        if ($urandom_range(99) < 60)
            it.pulse_us = 16'($urandom_range(hi, lo));
        else
            it.pulse_us = 16'($urandom);
        // time mostly advances around the timeout, sometimes jumps anywhere
        span = servo_cfg.timeout_ms;
        pick = $urandom_range(99);
        if (pick < 60)
            wall_ms += 32'($urandom_range(span + span / 4 + 2));
        else if (pick < 90)
            wall_ms += 32'($urandom_range(20));
        else
            wall_ms = $urandom;
        it.now = wall_ms;
        return it;
    endfunction

    function automatic servo_settings_t random_settings();
        servo_settings_t s;
        if ($urandom_range(1) == 1)
        begin
            s.min_us = 16'($urandom_range(1200, 500));
            s.max_us = 16'($urandom_range(2500, 1800));
            s.neutral_us = 16'($urandom_range(s.max_us, s.min_us));
            s.frame_us = 20'($urandom_range(25000, 2500));
            s.reload = 16'($urandom_range(65535, 1000));
            s.chan_id = 8'($urandom);
            s.timeout_ms = 16'($urandom_range(1000, 5));
        end
        else
        begin
            s = '{16'($urandom), 16'($urandom), 16'($urandom), 20'($urandom),
                  16'($urandom), 8'($urandom), 16'($urandom)};
            if ($urandom_range(3) == 0)
                s.max_us = s.min_us;
        end
        return s;
    endfunction

    // fixed corner settings first, then random ones
    function automatic servo_settings_t phase_settings(input int phase);
        case (phase)
            0: return RESET_SETTINGS;
            1: return '{16'd1500, 16'd1500, 16'd1500, 20'd20000, 16'd65535, 8'd0, 16'd0};
            2: return '{16'd2000, 16'd1000, 16'd1200, 20'd0, 16'd0, 8'd255, 16'd65535};
            3: return '{16'hFFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 16'hFFFF, 8'hFF, 16'hFFFF};
            4: return '0;
            5: return '{16'd0, 16'd65535, 16'd32768, 20'd1, 16'd65535, 8'h5A, 16'd20};
            6: return '{16'd900, 16'd2100, 16'd1500, 20'd1000000, 16'd49999, 8'h3C, 16'd250};
            default: return random_settings();
        endcase
    endfunction

    // write every register back to back, optionally poking the unused index too
    task automatic apply_settings(input servo_settings_t s, input bit poke_unused);
        logic [2:0] idx;
        for (int i = 0; i < 8; i++)
        begin
            idx = 3'(i);
            if (idx == CFG_UNUSED && !poke_unused)
                continue;
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            case (idx)
                CFG_MIN_PULSE: cfg_data <= 20'(s.min_us);
                CFG_MAX_PULSE: cfg_data <= 20'(s.max_us);
                CFG_NEUTRAL:   cfg_data <= 20'(s.neutral_us);
                CFG_PERIOD:    cfg_data <= s.frame_us;
                CFG_RELOAD:    cfg_data <= 20'(s.reload);
                CFG_CHAN_ID:   cfg_data <= 20'(s.chan_id);
                CFG_TIMEOUT:   cfg_data <= 20'(s.timeout_ms);
                default:       cfg_data <= 20'($urandom);
            endcase
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        servo_cfg = s;
    endtask

    // offer one request word, queue its reply once accepted
    task automatic send_word(input servo_item_t it, input bit typed, input servo_result_t want);
        servo_result_t predicted;
        while (idle_on && $urandom_range(99) < 31)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= it.req_type;
        servo_index <= it.servo_idx;
        position_cmd <= it.position;
        pulse_cmd_us <= it.pulse_us;
        now_ms <= it.now;
        do @(posedge clk); while (!in_ready);
        predicted = servo_reply(it);
        pending_replies.push_back(typed ? want : predicted);
    endtask

    // called in the step of the last accept, so valid drops right away
    task automatic drain_replies();
        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    function automatic void field_check(input string name, input logic [15:0] want,
                                        input logic [15:0] seen);
        if (seen !== want)
        begin
            $error("%s: expected 'h%0h, got 'h%0h", name, want, seen);
            fail_count++;
        end
    endfunction

    // stimulus
    initial
    begin
        servo_settings_t s;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        for (int phase = 0; phase < N_PHASES; phase++)
        begin
            s = phase_settings(phase);
            if (phase > 0)
            begin
                drain_replies();
                apply_settings(s, (phase % 3) == 2);
            end
            idle_on <= (phase != STEADY_PHASE);
            if (phase == 0)
            begin
                for (int r = 0; r < N_DIRECTED; r++)
                    send_word(DIRECTED_ROWS[r].item, DIRECTED_ROWS[r].typed,
                              DIRECTED_ROWS[r].want);
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (phase == HOLD_PHASE && n == 10)
                    hold_requests <= hold_requests + 1;
                if (phase == PAUSE_PHASE && n == 20)
                    drain_replies();
                send_word(random_item(), 1'b0, NO_REPLY);
            end
        end
        drain_replies();
        repeat (FLUSH_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_replies.size() == 0)
            $display("servo_pulse_command_failsafe_top test passed");
        else
            $display("servo_pulse_command_failsafe_top test failed");
        $finish;
    end

    // result side: check each accepted word, random stalls and one long hold
    initial
    begin
        servo_result_t want;
        int            hold_left;
        int            hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (pending_replies.size() == 0)
                begin
                    $error("result word with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want = pending_replies.pop_front();
                    field_check("compare_ticks", want.ticks, compare_ticks);
                    field_check("compare_write", 16'(want.cmp_wr), 16'(compare_write));
                    field_check("failsafe_fired", 16'(want.fired), 16'(failsafe_fired));
                    field_check("status_ok", 16'(want.ok), 16'(status_ok));
                    field_check("status_id", 16'(want.id), 16'(status_id));
                    field_check("status_position", want.position, status_position);
                end
            end
            if (hold_requests != hold_seen)
            begin
                hold_seen = hold_requests;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= !(idle_on && $urandom_range(99) < 31);
        end
    end

    // watchdog on cycles with no word accepted anywhere
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("servo_pulse_command_failsafe_top test failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
